[design/gcts_pkg.sv]
package gcts_pkg;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_PREP = 3'd1;
  localparam logic [2:0] M_WORK = 3'd2;
  localparam logic [2:0] M_TURN = 3'd3;
  localparam logic [2:0] M_DONE = 3'd4;

  localparam logic [3:0] S_NONE  = 4'd0;
  localparam logic [3:0] S_SEND  = 4'd1;
  localparam logic [3:0] S_WACK  = 4'd2;
  localparam logic [3:0] S_WTIME = 4'd3;
  localparam logic [3:0] S_BAL   = 4'd4;
  localparam logic [3:0] S_FWD   = 4'd5;
  localparam logic [3:0] S_BWD   = 4'd6;
  localparam logic [3:0] S_STOP  = 4'd7;
  localparam logic [3:0] S_GRIND = 4'd8;
  localparam logic [3:0] S_CHECK = 4'd9;
  localparam logic [3:0] S_PATH  = 4'd10;
  localparam logic [3:0] S_SPIN  = 4'd11;

  localparam logic [3:0] C_NONE  = 4'd0;
  localparam logic [3:0] C_BAL   = 4'd1;
  localparam logic [3:0] C_DOWN  = 4'd3;
  localparam logic [3:0] C_GRIND = 4'd4;
  localparam logic [3:0] C_FWD   = 4'd5;
  localparam logic [3:0] C_BWD   = 4'd6;
  localparam logic [3:0] C_TURN  = 4'd7;
  localparam logic [3:0] C_STOP  = 4'd8;
  localparam logic [3:0] C_SPON  = 4'd9;
  localparam logic [3:0] C_SPOFF = 4'd10;

  localparam logic [1:0] A_NONE = 2'd0;
  localparam logic [1:0] A_CART = 2'd1;
  localparam logic [1:0] A_STEP = 2'd2;
  localparam logic [1:0] A_SPIN = 2'd3;

  localparam logic [2:0] L_NONE   = 3'd0;
  localparam logic [2:0] L_YELLOW = 3'd1;
  localparam logic [2:0] L_BLUE   = 3'd2;
  localparam logic [2:0] L_GREEN  = 3'd3;
  localparam logic [2:0] L_RED    = 3'd4;

  localparam logic [7:0] F_BAL   = 8'h01;
  localparam logic [7:0] F_FWD   = 8'h02;
  localparam logic [7:0] F_BWD   = 8'h04;
  localparam logic [7:0] F_STOP  = 8'h08;
  localparam logic [7:0] F_SPIN  = 8'h10;
  localparam logic [7:0] F_GRIND = 8'h20;
  localparam logic [7:0] F_TURN  = 8'h40;

  localparam logic [1:0] TF_DONE = 2'd2;
  localparam logic [1:0] TF_RUN  = 2'd1;

  localparam logic [2:0] R_STEP_TOTAL = 3'd0;
  localparam logic [2:0] R_LOOP_TOTAL = 3'd1;
  localparam logic [2:0] R_FWD_TIME   = 3'd2;
  localparam logic [2:0] R_BWD_TIME   = 3'd3;
  localparam logic [2:0] R_ACK_TMO    = 3'd4;
  localparam logic [2:0] R_RETRY      = 3'd5;
  localparam logic [2:0] R_SPIN_SET   = 3'd6;
  localparam logic [2:0] R_TURN_TIME  = 3'd7;

  typedef struct packed {
    logic [7:0]  stops_per_pass;
    logic [7:0]  loop_limit;
    logic [31:0] forward_time_ms;
    logic [31:0] backward_time_ms;
    logic [31:0] ack_timeout_ms;
    logic [31:0] retry_ms;
    logic [31:0] spin_settle_ms;
    logic [31:0] turn_time_ms;
  } cfg_t;

  typedef struct packed {
    logic        start_req;
    logic [31:0] now_ms;
    logic [7:0]  cart_ack_code;
    logic [7:0]  stepper_code;
    logic [7:0]  spindle_status;
  } tick_t;

  typedef struct packed {
    logic [3:0] command;
    logic [3:0] sequence_id;
    logic [1:0] consume_ack;
    logic [2:0] lamp;
    logic [2:0] main_state_out;
    logic [3:0] sub_state_out;
    logic [7:0] fwd_stops_out;
    logic [7:0] bwd_stops_out;
    logic [7:0] loops_done_out;
    logic       task_done;
  } result_t;

endpackage

[design/gcts_cfg_regs.sv]
module gcts_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output gcts_pkg::cfg_t     cfg
);
  import gcts_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stops_per_pass   <= 8'd0;
      cfg.loop_limit       <= 8'd0;
      cfg.forward_time_ms  <= 32'd1000;
      cfg.backward_time_ms <= 32'd1000;
      cfg.ack_timeout_ms   <= 32'd80000;
      cfg.retry_ms         <= 32'd2000;
      cfg.spin_settle_ms   <= 32'd6000;
      cfg.turn_time_ms     <= 32'd500;
    end else if (wr) begin
      case (idx)
        R_STEP_TOTAL: cfg.stops_per_pass   <= pwdata[7:0];
        R_LOOP_TOTAL: cfg.loop_limit       <= pwdata[7:0];
        R_FWD_TIME:   cfg.forward_time_ms  <= pwdata;
        R_BWD_TIME:   cfg.backward_time_ms <= pwdata;
        R_ACK_TMO:    cfg.ack_timeout_ms   <= pwdata;
        R_RETRY:      cfg.retry_ms         <= pwdata;
        R_SPIN_SET:   cfg.spin_settle_ms   <= pwdata;
        R_TURN_TIME:  cfg.turn_time_ms     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      R_STEP_TOTAL: prdata = {24'd0, cfg.stops_per_pass};
      R_LOOP_TOTAL: prdata = {24'd0, cfg.loop_limit};
      R_FWD_TIME:   prdata = cfg.forward_time_ms;
      R_BWD_TIME:   prdata = cfg.backward_time_ms;
      R_ACK_TMO:    prdata = cfg.ack_timeout_ms;
      R_RETRY:      prdata = cfg.retry_ms;
      R_SPIN_SET:   prdata = cfg.spin_settle_ms;
      default:      prdata = cfg.turn_time_ms;
    endcase
  end
endmodule

[design/gcts_core.sv]
module gcts_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  gcts_pkg::tick_t   tick,
  input  gcts_pkg::cfg_t    cfg,
  output gcts_pkg::result_t res
);
  import gcts_pkg::*;

  logic [2:0]  main_state, main_state_next;
  logic [3:0]  sub_state, sub_state_next;
  logic [1:0]  task_flag, task_flag_next;
  logic [31:0] wait_stamp, wait_stamp_next;
  logic [31:0] move_stamp, move_stamp_next;
  logic [31:0] stop_stamp, stop_stamp_next;
  logic [31:0] spin_stamp, spin_stamp_next;
  logic [31:0] grind_stamp, grind_stamp_next;
  logic [31:0] turn_stamp, turn_stamp_next;
  logic [7:0]  sent_flags, sent_flags_next;
  logic        forward_phase, forward_phase_next;
  logic [7:0]  fwd_stops, fwd_stops_next;
  logic [7:0]  bwd_stops, bwd_stops_next;
  logic [7:0]  loops_done, loops_done_next;
  logic [1:0]  shutdown_step, shutdown_step_next;
  logic [3:0]  cmd, seq;
  logic [1:0]  consume;
  logic [2:0]  lamp;
  logic [31:0] now;

  function automatic logic el(input logic [31:0] n, input logic [31:0] s,
                              input logic [31:0] span);
    logic [31:0] d;
    d = n - s;
    return d >= span;
  endfunction

  always_comb begin
    logic       ok;
    logic [7:0] fc;
    logic [7:0] bc;
    logic [7:0] ld;
    ok   = 1'b0;
    fc   = 8'd0;
    bc   = 8'd0;
    ld   = 8'd0;
    now  = tick.now_ms;
    cmd = C_NONE; seq = 4'd0; consume = A_NONE; lamp = L_NONE;
    main_state_next = main_state; sub_state_next = sub_state;
    task_flag_next = task_flag; wait_stamp_next = wait_stamp;
    move_stamp_next = move_stamp; stop_stamp_next = stop_stamp;
    spin_stamp_next = spin_stamp; grind_stamp_next = grind_stamp;
    turn_stamp_next = turn_stamp; sent_flags_next = sent_flags;
    forward_phase_next = forward_phase; fwd_stops_next = fwd_stops;
    bwd_stops_next = bwd_stops; loops_done_next = loops_done;
    shutdown_step_next = shutdown_step;

    if (tick.start_req) begin
      task_flag_next = TF_RUN;
      shutdown_step_next = 2'd0;
      loops_done_next = 8'd0;
      fwd_stops_next = 8'd0;
      bwd_stops_next = 8'd0;
      forward_phase_next = 1'b0;
      sent_flags_next = sent_flags_next & ~(F_STOP | F_GRIND | F_BAL);
      move_stamp_next = 32'd0; stop_stamp_next = 32'd0; turn_stamp_next = 32'd0;
      spin_stamp_next = 32'd0; grind_stamp_next = 32'd0;
    end

    if (task_flag_next != TF_DONE) begin
      if (cfg.stops_per_pass == 8'd0 || cfg.loop_limit == 8'd0) begin
        lamp = L_RED;
        main_state_next = M_IDLE;
      end else begin
        case (main_state)
          M_IDLE: begin
            fwd_stops_next = 8'd0;
            bwd_stops_next = 8'd0;
            forward_phase_next = 1'b1;
            sent_flags_next = sent_flags_next & ~(F_STOP | F_GRIND);
            shutdown_step_next = 2'd0;
            loops_done_next = 8'd0;
            main_state_next = M_PREP;
            sub_state_next = S_SEND;
            lamp = L_YELLOW;
          end
          M_PREP: begin
            case (sub_state)
              S_SEND: begin
                cmd = C_DOWN; seq = 4'd1;
                wait_stamp_next = now;
                sub_state_next = S_WACK;
              end
              S_WACK: begin
                if (tick.stepper_code == 8'd3) begin
                  consume = A_STEP; ok = 1'b1;
                end else ok = el(now, wait_stamp, cfg.ack_timeout_ms);
                if (ok) begin
                  sub_state_next = S_WTIME;
                  wait_stamp_next = now;
                end else if (el(now, wait_stamp, cfg.retry_ms)) begin
                  sub_state_next = S_SEND;
                end
              end
              S_WTIME: begin
                if (el(now, wait_stamp, cfg.retry_ms)) sub_state_next = S_BAL;
              end
              S_BAL: begin
                if ((sent_flags_next & F_BAL) == 8'd0) begin
                  cmd = C_BAL; seq = 4'd5;
                  sent_flags_next = sent_flags_next | F_BAL;
                  wait_stamp_next = now;
                end
                if (tick.stepper_code == 8'd1) begin
                  consume = A_STEP; ok = 1'b1;
                end else ok = el(now, wait_stamp_next, cfg.ack_timeout_ms);
                if (ok) begin
                  forward_phase_next = 1'b1;
                  main_state_next = M_WORK;
                  sub_state_next = S_SEND;
                end else if (el(now, wait_stamp_next, cfg.retry_ms)) begin
                  sent_flags_next = sent_flags_next & ~F_BAL;
                end
              end
              default: sub_state_next = S_SEND;
            endcase
          end
          M_WORK: begin
            case (sub_state)
              S_SEND: begin
                cmd = C_SPON; seq = 4'd2;
                wait_stamp_next = now;
                sub_state_next = S_WACK;
              end
              S_WACK: begin
                if (tick.spindle_status == 8'd1) begin
                  consume = A_SPIN; ok = 1'b1;
                end else ok = el(now, wait_stamp, cfg.ack_timeout_ms);
                if (ok) begin
                  sub_state_next = S_WTIME;
                  wait_stamp_next = now;
                end else if (el(now, wait_stamp, cfg.retry_ms)) begin
                  sub_state_next = S_SEND;
                end
              end
              S_WTIME: begin
                if (el(now, wait_stamp, cfg.spin_settle_ms)) begin
                  sent_flags_next = sent_flags_next & ~F_STOP;
                  sub_state_next = forward_phase_next ? S_FWD : S_BWD;
                end
              end
              S_FWD: begin
                if ((sent_flags_next & F_FWD) == 8'd0) begin
                  cmd = C_FWD; seq = 4'd3; lamp = L_BLUE;
                  move_stamp_next = now;
                  sent_flags_next = sent_flags_next | F_FWD;
                end
                if (el(now, move_stamp_next, cfg.forward_time_ms)) begin
                  sent_flags_next = sent_flags_next & ~(F_FWD | F_STOP);
                  sub_state_next = S_STOP;
                end
              end
              S_BWD: begin
                if ((sent_flags_next & F_BWD) == 8'd0) begin
                  cmd = C_BWD; seq = 4'd4; lamp = L_GREEN;
                  move_stamp_next = now;
                  sent_flags_next = sent_flags_next | F_BWD;
                end
                if (el(now, move_stamp_next, cfg.backward_time_ms)) begin
                  sent_flags_next = sent_flags_next & ~(F_BWD | F_STOP);
                  sub_state_next = S_STOP;
                end
              end
              S_STOP: begin
                if ((sent_flags_next & F_STOP) == 8'd0) begin
                  cmd = C_STOP; seq = 4'd5; lamp = L_RED;
                  stop_stamp_next = now;
                  sent_flags_next = sent_flags_next | F_STOP;
                end
                if (tick.cart_ack_code == 8'd2) begin
                  consume = A_CART; ok = 1'b1;
                end else ok = el(now, stop_stamp_next, cfg.ack_timeout_ms);
                if (ok) begin
                  sent_flags_next = sent_flags_next & ~F_STOP;
                  sub_state_next = S_SPIN;
                end
              end
              S_SPIN: begin
                if ((sent_flags_next & F_SPIN) == 8'd0) begin
                  cmd = C_SPON; seq = 4'd6;
                  spin_stamp_next = now;
                  sent_flags_next = sent_flags_next | F_SPIN;
                end
                if (tick.spindle_status == 8'd1) begin
                  consume = A_SPIN; ok = 1'b1;
                end else ok = el(now, spin_stamp_next, cfg.ack_timeout_ms);
                if (ok) begin
                  sent_flags_next = sent_flags_next & ~(F_SPIN | F_GRIND);
                  sub_state_next = S_GRIND;
                end else if (el(now, spin_stamp_next, cfg.retry_ms)) begin
                  sent_flags_next = sent_flags_next & ~F_SPIN;
                end
              end
              S_GRIND: begin
                if ((sent_flags_next & F_GRIND) == 8'd0) begin
                  cmd = C_GRIND; seq = 4'd7;
                  grind_stamp_next = now;
                  sent_flags_next = sent_flags_next | F_GRIND;
                end
                if (tick.stepper_code == 8'd2) begin
                  consume = A_STEP; ok = 1'b1;
                end else ok = el(now, grind_stamp_next, cfg.ack_timeout_ms);
                if (ok) begin
                  sent_flags_next = sent_flags_next & ~F_GRIND;
                  sub_state_next = S_CHECK;
                end else if (el(now, grind_stamp_next, cfg.retry_ms)) begin
                  sent_flags_next = sent_flags_next & ~F_GRIND;
                end
              end
              S_CHECK: begin
                fc = fwd_stops_next + 8'd1;
                bc = bwd_stops_next + 8'd1;
                if (forward_phase_next) begin
                  fwd_stops_next = fc;
                  if (fc >= cfg.stops_per_pass) main_state_next = M_TURN;
                end else begin
                  bwd_stops_next = bc;
                  if (bc >= cfg.loop_limit) main_state_next = M_TURN;
                end
                sub_state_next = S_SEND;
              end
              default: sub_state_next = S_SEND;
            endcase
          end
          M_TURN: begin
            case (sub_state)
              S_SEND: begin
                if ((sent_flags_next & F_TURN) == 8'd0) begin
                  cmd = C_TURN; seq = 4'd8;
                  turn_stamp_next = now;
                  sent_flags_next = sent_flags_next | F_TURN;
                end
                if (el(now, turn_stamp_next, cfg.turn_time_ms)) begin
                  sent_flags_next = sent_flags_next & ~(F_TURN | F_STOP);
                  sub_state_next = S_STOP;
                end
              end
              S_STOP: begin
                if ((sent_flags_next & F_STOP) == 8'd0) begin
                  cmd = C_STOP; seq = 4'd5;
                  stop_stamp_next = now;
                  sent_flags_next = sent_flags_next | F_STOP;
                end
                if (tick.cart_ack_code == 8'd2) begin
                  consume = A_CART; ok = 1'b1;
                end else ok = el(now, stop_stamp_next, cfg.ack_timeout_ms);
                if (ok) begin
                  sent_flags_next = sent_flags_next & ~F_STOP;
                  sub_state_next = S_PATH;
                end else if (el(now, stop_stamp_next, cfg.retry_ms)) begin
                  sent_flags_next = sent_flags_next & ~F_STOP;
                end
              end
              S_PATH: begin
                if (forward_phase_next) begin
                  forward_phase_next = 1'b0;
                  main_state_next = M_WORK;
                  sub_state_next = S_SEND;
                end else begin
                  ld = loops_done_next + 8'd1;
                  loops_done_next = ld;
                  forward_phase_next = 1'b1;
                  fwd_stops_next = 8'd0;
                  bwd_stops_next = 8'd0;
                  if (ld < cfg.loop_limit) begin
                    main_state_next = M_WORK;
                    sub_state_next = S_SEND;
                  end else begin
                    shutdown_step_next = 2'd0;
                    main_state_next = M_DONE;
                  end
                end
              end
              default: sub_state_next = S_SEND;
            endcase
          end
          M_DONE: begin
            case (shutdown_step_next)
              2'd0: begin
                cmd = C_STOP; seq = 4'd10;
                stop_stamp_next = now;
                shutdown_step_next = 2'd1;
              end
              2'd1: begin
                if (tick.cart_ack_code == 8'd2) begin
                  consume = A_CART; ok = 1'b1;
                end else ok = el(now, stop_stamp_next, cfg.ack_timeout_ms);
                if (ok) shutdown_step_next = 2'd2;
              end
              2'd2: begin
                cmd = C_SPOFF; seq = 4'd11;
                spin_stamp_next = now;
                shutdown_step_next = 2'd3;
              end
              default: begin
                if (tick.spindle_status == 8'd2) begin
                  consume = A_SPIN; ok = 1'b1;
                end else ok = el(now, spin_stamp_next, cfg.ack_timeout_ms);
                if (ok) begin
                  shutdown_step_next = 2'd0;
                  main_state_next = M_IDLE;
                  task_flag_next = TF_DONE;
                end else if (el(now, spin_stamp_next, cfg.retry_ms)) begin
                  shutdown_step_next = 2'd2;
                end
              end
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_state <= M_IDLE; sub_state <= S_NONE; task_flag <= 2'd0;
      wait_stamp <= 32'd0; move_stamp <= 32'd0; stop_stamp <= 32'd0;
      spin_stamp <= 32'd0; grind_stamp <= 32'd0; turn_stamp <= 32'd0;
      sent_flags <= 8'd0; forward_phase <= 1'b0; fwd_stops <= 8'd0;
      bwd_stops <= 8'd0; loops_done <= 8'd0; shutdown_step <= 2'd0;
    end else if (step) begin
      main_state <= main_state_next; sub_state <= sub_state_next;
      task_flag <= task_flag_next; wait_stamp <= wait_stamp_next;
      move_stamp <= move_stamp_next; stop_stamp <= stop_stamp_next;
      spin_stamp <= spin_stamp_next; grind_stamp <= grind_stamp_next;
      turn_stamp <= turn_stamp_next; sent_flags <= sent_flags_next;
      forward_phase <= forward_phase_next; fwd_stops <= fwd_stops_next;
      bwd_stops <= bwd_stops_next; loops_done <= loops_done_next;
      shutdown_step <= shutdown_step_next;
    end
  end

  always_comb begin
    res.command            = cmd;
    res.sequence_id        = seq;
    res.consume_ack        = consume;
    res.lamp               = lamp;
    res.main_state_out     = main_state_next;
    res.sub_state_out      = sub_state_next;
    res.fwd_stops_out      = fwd_stops_next;
    res.bwd_stops_out      = bwd_stops_next;
    res.loops_done_out     = loops_done_next;
    res.task_done          = (task_flag_next == TF_DONE);
  end
endmodule

[design/grinding_cart_task_sequencer.sv]
// Grinding cart task sequencer.
// Input stream: one transfer per main-loop tick; tdata carries start_req,
// now_ms and the cart, stepper and spindle reply bytes.
// Output stream: one transfer per tick with the command, sequence id,
// consumed reply, lamp colour, states, counters and done flag.
// Configuration: APB registers at byte address 4*i (totals, drive times,
// ack timeout, retry period, spin settle, turn time); write only while idle.
// The tick is held in an input register, the sequencer state and result are
// computed by one pass of combinational logic into the output register, and
// one tick is taken every cycle while the receiver does not stall. The tick
// register advances whenever the output register is empty or being drained,
// so a stalled receiver holds the result and backs up tready after at most
// two ticks in flight.
// Reset clears the sequencer to idle, the registers to their defaults and
// empties both pipeline registers.
module grinding_cart_task_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // {spindle_status, stepper_code, cart_ack_code, now_ms, start_req} from bit 0
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // command, sequence_id, consume_ack, lamp, main_state_out, sub_state_out,
  // fwd_stops_out, bwd_stops_out, loops_done_out, task_done from bit 0
  output logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gcts_pkg::*;

  cfg_t    cfg;
  tick_t   tick;
  result_t res;
  logic    in_valid;
  logic    adv;

  gcts_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      tick.start_req      <= s_tdata[0];
      tick.now_ms         <= s_tdata[32:1];
      tick.cart_ack_code  <= s_tdata[40:33];
      tick.stepper_code   <= s_tdata[48:41];
      tick.spindle_status <= s_tdata[56:49];
    end
  end

  gcts_core u_core (.clk, .rst, .step(adv), .tick, .cfg, .res);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {3'b000, res.task_done, res.loops_done_out, res.bwd_stops_out,
                  res.fwd_stops_out, res.sub_state_out, res.main_state_out,
                  res.lamp, res.consume_ack, res.sequence_id, res.command};
    end
  end
endmodule

[design/gcts_checker.sv]
module gcts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);
  import gcts_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped under stall");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] == C_NONE |-> m_tdata[7:4] == 4'd0)
    else $error("sequence id without command");

  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[44] |-> m_tdata[3:0] == C_NONE && m_tdata[15:13] == M_IDLE)
    else $error("activity while done");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");
endmodule

bind grinding_cart_task_sequencer gcts_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

[test/grinding_cart_task_sequencer_tb.sv]
`timescale 1ns / 100ps

module grinding_cart_task_sequencer_tb;
  import gcts_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // {spindle_status, stepper_code, cart_ack_code, now_ms, start_req} from bit 0
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // command, sequence_id, consume_ack, lamp, main_state_out, sub_state_out,
  // fwd_stops_out, bwd_stops_out, loops_done_out, task_done from bit 0
  logic [47:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grinding_cart_task_sequencer DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  logic [63:0] tick_q[$];
  result_t     want_q[$];
  int          tx_idle = 31;
  int          rx_idle = 80;
  int          errors = 0;
  int          results_seen = 0;
  int          tasks_finished = 0;
  int          settings_used = 0;
  int          quiet_cycles = 0;
  bit          taken = 1'b0;

  // sequencer shadow state
  cfg_t        cfg;
  logic [2:0]  ms;
  logic [3:0]  ss;
  logic [1:0]  tf, sd;
  logic [31:0] ws, mvs, sts, sps, grs, tus;
  logic [7:0]  flags, fc, bc, loops;
  logic        fp;
  logic [31:0] now_v;
  logic [7:0]  a_cart, a_step, a_spin;
  logic [3:0]  r_cmd, r_seq;
  logic [1:0]  r_cons;
  logic [2:0]  r_lamp;

  function automatic bit gone(logic [31:0] stamp, logic [31:0] span);
    logic [31:0] diff;
    diff = now_v - stamp;
    return diff >= span;
  endfunction

  function automatic bit got_ack(logic [1:0] src, logic [7:0] code, logic [31:0] stamp);
    logic [7:0] v;
    v = (src == A_CART) ? a_cart : (src == A_STEP) ? a_step : a_spin;
    if (v == code) begin
      r_cons = src;
      return 1'b1;
    end
    return gone(stamp, cfg.ack_timeout_ms);
  endfunction

  task automatic issue(logic [3:0] c, logic [3:0] s);
    r_cmd = c;
    r_seq = s;
  endtask

  task automatic sequencer_reset();
    cfg = '{8'd0, 8'd0, 32'd1000, 32'd1000, 32'd80000, 32'd2000, 32'd6000, 32'd500};
    ms = M_IDLE; ss = S_NONE; tf = 2'd0; sd = 2'd0;
    ws = '0; mvs = '0; sts = '0; sps = '0; grs = '0; tus = '0;
    flags = '0; fc = '0; bc = '0; loops = '0; fp = 1'b0;
  endtask

  task automatic step_prepare();
    case (ss)
      S_SEND: begin
        issue(C_DOWN, 4'd1); ws = now_v; ss = S_WACK;
      end
      S_WACK: begin
        if (got_ack(A_STEP, 8'd3, ws)) begin
          ss = S_WTIME; ws = now_v;
        end else if (gone(ws, cfg.retry_ms)) ss = S_SEND;
      end
      S_WTIME: if (gone(ws, cfg.retry_ms)) ss = S_BAL;
      S_BAL: begin
        if (!(flags & F_BAL)) begin
          issue(C_BAL, 4'd5); flags |= F_BAL; ws = now_v;
        end
        if (got_ack(A_STEP, 8'd1, ws)) begin
          fp = 1'b1; ms = M_WORK; ss = S_SEND;
        end else if (gone(ws, cfg.retry_ms)) flags &= ~F_BAL;
      end
      default: ss = S_SEND;
    endcase
  endtask

  task automatic step_working();
    case (ss)
      S_SEND: begin
        issue(C_SPON, 4'd2); ws = now_v; ss = S_WACK;
      end
      S_WACK: begin
        if (got_ack(A_SPIN, 8'd1, ws)) begin
          ss = S_WTIME; ws = now_v;
        end else if (gone(ws, cfg.retry_ms)) ss = S_SEND;
      end
      S_WTIME: begin
        if (gone(ws, cfg.spin_settle_ms)) begin
          flags &= ~F_STOP; ss = fp ? S_FWD : S_BWD;
        end
      end
      S_FWD: begin
        if (!(flags & F_FWD)) begin
          issue(C_FWD, 4'd3); r_lamp = L_BLUE; mvs = now_v; flags |= F_FWD;
        end
        if (gone(mvs, cfg.forward_time_ms)) begin
          flags &= ~(F_FWD | F_STOP); ss = S_STOP;
        end
      end
      S_BWD: begin
        if (!(flags & F_BWD)) begin
          issue(C_BWD, 4'd4); r_lamp = L_GREEN; mvs = now_v; flags |= F_BWD;
        end
        if (gone(mvs, cfg.backward_time_ms)) begin
          flags &= ~(F_BWD | F_STOP); ss = S_STOP;
        end
      end
      S_STOP: begin
        if (!(flags & F_STOP)) begin
          issue(C_STOP, 4'd5); r_lamp = L_RED; sts = now_v; flags |= F_STOP;
        end
        if (got_ack(A_CART, 8'd2, sts)) begin
          flags &= ~F_STOP; ss = S_SPIN;
        end
      end
      S_SPIN: begin
        if (!(flags & F_SPIN)) begin
          issue(C_SPON, 4'd6); sps = now_v; flags |= F_SPIN;
        end
        if (got_ack(A_SPIN, 8'd1, sps)) begin
          flags &= ~(F_SPIN | F_GRIND); ss = S_GRIND;
        end else if (gone(sps, cfg.retry_ms)) flags &= ~F_SPIN;
      end
      S_GRIND: begin
        if (!(flags & F_GRIND)) begin
          issue(C_GRIND, 4'd7); grs = now_v; flags |= F_GRIND;
        end
        if (got_ack(A_STEP, 8'd2, grs)) begin
          flags &= ~F_GRIND; ss = S_CHECK;
        end else if (gone(grs, cfg.retry_ms)) flags &= ~F_GRIND;
      end
      S_CHECK: begin
        if (fp) fc = fc + 8'd1;
        else bc = bc + 8'd1;
        if ((fp && fc >= cfg.stops_per_pass) || (!fp && bc >= cfg.loop_limit)) ms = M_TURN;
        ss = S_SEND;
      end
      default: ss = S_SEND;
    endcase
  endtask

  task automatic step_turning();
    case (ss)
      S_SEND: begin
        if (!(flags & F_TURN)) begin
          issue(C_TURN, 4'd8); tus = now_v; flags |= F_TURN;
        end
        if (gone(tus, cfg.turn_time_ms)) begin
          flags &= ~(F_TURN | F_STOP); ss = S_STOP;
        end
      end
      S_STOP: begin
        if (!(flags & F_STOP)) begin
          issue(C_STOP, 4'd5); sts = now_v; flags |= F_STOP;
        end
        if (got_ack(A_CART, 8'd2, sts)) begin
          flags &= ~F_STOP; ss = S_PATH;
        end else if (gone(sts, cfg.retry_ms)) flags &= ~F_STOP;
      end
      S_PATH: begin
        if (fp) begin
          fp = 1'b0; ms = M_WORK; ss = S_SEND;
        end else begin
          loops = loops + 8'd1; fp = 1'b1; fc = '0; bc = '0;
          if (loops < cfg.loop_limit) begin
            ms = M_WORK; ss = S_SEND;
          end else begin
            sd = 2'd0; ms = M_DONE;
          end
        end
      end
      default: ss = S_SEND;
    endcase
  endtask

  task automatic step_shutdown();
    case (sd)
      2'd0: begin
        issue(C_STOP, 4'd10); sts = now_v; sd = 2'd1;
      end
      2'd1: if (got_ack(A_CART, 8'd2, sts)) sd = 2'd2;
      2'd2: begin
        issue(C_SPOFF, 4'd11); sps = now_v; sd = 2'd3;
      end
      default: begin
        if (got_ack(A_SPIN, 8'd2, sps)) begin
          sd = 2'd0; ms = M_IDLE; tf = TF_DONE; tasks_finished++;
        end else if (gone(sps, cfg.retry_ms)) sd = 2'd2;
      end
    endcase
  endtask

  task automatic predict_tick(input logic [63:0] d, output result_t r);
    now_v = d[32:1]; a_cart = d[40:33]; a_step = d[48:41]; a_spin = d[56:49];
    r_cmd = C_NONE; r_seq = '0; r_cons = A_NONE; r_lamp = L_NONE;
    if (d[0]) begin
      tf = TF_RUN; sd = 2'd0; loops = '0; fc = '0; bc = '0; fp = 1'b0;
      flags &= ~(F_STOP | F_GRIND | F_BAL);
      mvs = '0; sts = '0; tus = '0; sps = '0; grs = '0;
    end
    if (tf != TF_DONE) begin
      if (cfg.stops_per_pass == 0 || cfg.loop_limit == 0) begin
        r_lamp = L_RED; ms = M_IDLE;
      end else begin
        case (ms)
          M_IDLE: begin
            fc = '0; bc = '0; fp = 1'b1; flags &= ~(F_STOP | F_GRIND);
            sd = 2'd0; loops = '0; ms = M_PREP; ss = S_SEND; r_lamp = L_YELLOW;
          end
          M_PREP: step_prepare();
          M_WORK: step_working();
          M_TURN: step_turning();
          M_DONE: step_shutdown();
          default: ;
        endcase
      end
    end
    r.command = r_cmd; r.sequence_id = r_seq; r.consume_ack = r_cons; r.lamp = r_lamp;
    r.main_state_out = ms; r.sub_state_out = ss; r.fwd_stops_out = fc;
    r.bwd_stops_out = bc; r.loops_done_out = loops; r.task_done = (tf == TF_DONE);
  endtask

  task automatic field_check(string name, int want, int got, inout bit bad);
    if (want != got) begin
      bad = 1'b1;
      if (errors < 10)
        $display("result %0d %s: expected %0d, got %0d", results_seen, name, want, got);
    end
  endtask

  // input side: predict on transfer; output side: compare with oldest expectation
  always @(posedge clk) begin
    result_t w;
    result_t e;
    bit bad;
    if (!rst) begin
      taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        predict_tick(s_tdata, w);
        want_q.push_back(w);
      end
      if (m_tvalid && m_tready) begin
        bad = 1'b0;
        if (want_q.size() == 0) begin
          bad = 1'b1;
          if (errors < 10) $display("unexpected result transfer %h", m_tdata);
        end else begin
          e = want_q.pop_front();
          field_check("command", e.command, m_tdata[3:0], bad);
          field_check("sequence_id", e.sequence_id, m_tdata[7:4], bad);
          field_check("consume_ack", e.consume_ack, m_tdata[9:8], bad);
          field_check("lamp", e.lamp, m_tdata[12:10], bad);
          field_check("main_state", e.main_state_out, m_tdata[15:13], bad);
          field_check("sub_state", e.sub_state_out, m_tdata[19:16], bad);
          field_check("fwd_stops", e.fwd_stops_out, m_tdata[27:20], bad);
          field_check("bwd_stops", e.bwd_stops_out, m_tdata[35:28], bad);
          field_check("loops_done", e.loops_done_out, m_tdata[43:36], bad);
          field_check("task_done", e.task_done, m_tdata[44], bad);
        end
        if (bad) errors++;
        results_seen++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else if (quiet_cycles > 20000) begin
        $display("Mismatches found");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle);
      if (!s_tvalid || taken) begin
        if (tick_q.size() > 0 && $urandom_range(0, 99) >= tx_idle) begin
          s_tvalid <= 1'b1;
          s_tdata <= tick_q.pop_front();
        end else s_tvalid <= 1'b0;
      end
    end
  end

  task automatic add_tick(bit st, logic [31:0] t, logic [7:0] c, logic [7:0] s,
                          logic [7:0] p);
    tick_q.push_back({7'd0, p, s, c, t, st});
  endtask

  task automatic drain();
    while (tick_q.size() > 0 || s_tvalid || want_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      R_STEP_TOTAL: cfg.stops_per_pass = v[7:0];
      R_LOOP_TOTAL: cfg.loop_limit = v[7:0];
      R_FWD_TIME:   cfg.forward_time_ms = v;
      R_BWD_TIME:   cfg.backward_time_ms = v;
      R_ACK_TMO:    cfg.ack_timeout_ms = v;
      R_RETRY:      cfg.retry_ms = v;
      R_SPIN_SET:   cfg.spin_settle_ms = v;
      default:      cfg.turn_time_ms = v;
    endcase
  endtask

  task automatic load_setting(logic [7:0] st, logic [7:0] lt, logic [31:0] fw,
                              logic [31:0] bw, logic [31:0] tmo, logic [31:0] rt,
                              logic [31:0] ss_ms, logic [31:0] tn);
    reg_write(R_STEP_TOTAL, {24'hABCDEF, st});
    reg_write(R_LOOP_TOTAL, {24'h123456, lt});
    reg_write(R_FWD_TIME, fw);
    reg_write(R_BWD_TIME, bw);
    reg_write(R_ACK_TMO, tmo);
    reg_write(R_RETRY, rt);
    reg_write(R_SPIN_SET, ss_ms);
    reg_write(R_TURN_TIME, tn);
    settings_used++;
  endtask

  task automatic random_ticks(int n, inout logic [31:0] t);
    logic [7:0] c, s, p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) t = t + $urandom();
      else t = t + $urandom_range(0, 12);
      c = ($urandom_range(0, 1) == 0) ? 8'd2 : 8'($urandom());
      case ($urandom_range(0, 4))
        0: s = 8'd1;
        1: s = 8'd2;
        2: s = 8'd3;
        default: s = 8'($urandom());
      endcase
      case ($urandom_range(0, 4))
        0, 1: p = 8'd1;
        2: p = 8'd2;
        default: p = 8'($urandom());
      endcase
      add_tick($urandom_range(0, 63) == 0, t, c, s, p);
    end
  endtask

  initial begin
    logic [31:0] t;
    sequencer_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // totals still zero: red lamp whatever comes in
    add_tick(1'b1, 32'h0, 8'h00, 8'h00, 8'h00);
    add_tick(1'b0, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF);
    add_tick(1'b0, 32'h5555AAAA, 8'h02, 8'h01, 8'h01);
    drain();
    load_setting(8'd1, 8'd1, 32'd2, 32'd2, 32'd40, 32'd3, 32'd2, 32'd1);
    // preparation, one forward move and stop, then a restart, wrapping the timestamp
    t = 32'hFFFFFFFC;
    add_tick(1'b1, t, 8'h00, 8'h00, 8'h00);
    add_tick(1'b0, t, 8'h00, 8'h00, 8'h00);
    add_tick(1'b0, t + 1, 8'h00, 8'h03, 8'h00);
    add_tick(1'b0, t + 5, 8'h00, 8'h00, 8'h00);
    add_tick(1'b0, t + 5, 8'h00, 8'h01, 8'h00);
    add_tick(1'b0, t + 6, 8'h00, 8'h00, 8'h01);
    add_tick(1'b0, t + 9, 8'h00, 8'h00, 8'h00);
    add_tick(1'b0, t + 12, 8'h00, 8'h00, 8'h00);
    add_tick(1'b0, t + 13, 8'h02, 8'h00, 8'h01);
    add_tick(1'b0, t + 13, 8'h00, 8'h02, 8'h01);
    add_tick(1'b0, t + 14, 8'h00, 8'h02, 8'h00);
    add_tick(1'b0, t + 15, 8'h00, 8'h00, 8'h00);
    add_tick(1'b0, t + 17, 8'h02, 8'h00, 8'h00);
    add_tick(1'b0, t + 18, 8'h02, 8'h00, 8'h00);
    add_tick(1'b0, t + 200, 8'hFF, 8'hFF, 8'hFF);
    add_tick(1'b0, t + 300, 8'h02, 8'h00, 8'h02);
    add_tick(1'b0, t + 400, 8'h02, 8'h00, 8'h02);
    add_tick(1'b0, t + 401, 8'h00, 8'h00, 8'h00);
    add_tick(1'b1, t + 402, 8'h00, 8'h00, 8'h00);
    drain();

    t = 32'd0;
    load_setting(8'd2, 8'd1, 32'd5, 32'd5, 32'd30, 32'd6, 32'd4, 32'd3);
    random_ticks(320, t);
    drain();
    load_setting(8'd1, 8'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_ticks(320, t);
    drain();
    tx_idle = 80; rx_idle = 31;
    load_setting(8'd255, 8'd255, 32'd3, 32'd4, 32'd20, 32'd5, 32'd2, 32'd2);
    random_ticks(320, t);
    drain();
    load_setting(8'd3, 8'd0, 32'd3, 32'd3, 32'd20, 32'd5, 32'd2, 32'd2);
    random_ticks(100, t);
    drain();
    tx_idle = 0; rx_idle = 0;
    t = 32'hFFFFFF00;
    load_setting(8'd2, 8'd2, 32'd4, 32'd6, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd3,
                 32'hFFFFFFFF);
    random_ticks(300, t);
    drain();
    load_setting(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                 $urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 60),
                 $urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40));
    random_ticks(500, t);
    drain();
    repeat (10) @(posedge clk);

    $display("Checked %0d result transfers across %0d register settings;", results_seen,
             settings_used);
    $display("%0d grinding tasks ran through to shutdown.", tasks_finished);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[grinding_cart_task_sequencer.f]
design/gcts_pkg.sv
design/gcts_cfg_regs.sv
design/gcts_core.sv
design/grinding_cart_task_sequencer.sv
design/gcts_checker.sv
test/grinding_cart_task_sequencer_tb.sv
